>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> src/czoom_pkg.sv
`default_nettype none
package czoom_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int MAX_ZOOM      = 8;
  localparam int PIXEL_BITS    = 24;

  localparam int DIM_W       = 13;
  localparam int COORD_W     = 12;
  localparam int ZOOM_W      = 11;
  localparam int CTR_W       = 16;
  localparam int FRAC_W      = 8;
  localparam int GW          = 40;
  localparam int MA_W        = 26;
  localparam int PROD_W      = MA_W + ZOOM_W + 1;
  localparam int DIV_W       = 32;
  localparam int REM_W       = ZOOM_W + 1;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int MAX_WRITES  = MAX_ZOOM * MAX_ZOOM;
  localparam int WRITE_CNT_W = $clog2(MAX_WRITES);
  localparam int APB_W       = 32;
  localparam int ADDR_W      = 5;
  localparam int ZOOM_MAX_CODE = MAX_ZOOM * (2 ** FRAC_W) - 1;
  localparam int SAT_HI      = 2 ** (CTR_W - 1) - 1;
  localparam int SAT_LO      = -(2 ** (CTR_W - 1));

  typedef logic signed [GW-1:0] geo_t;

  typedef enum logic [2:0] {
    REG_SOURCE_WIDTH,
    REG_SOURCE_HEIGHT,
    REG_WINDOW_WIDTH,
    REG_WINDOW_HEIGHT,
    REG_ZOOM_FACTOR,
    REG_CENTER_X,
    REG_CENTER_Y
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]        source_width;
    logic [DIM_W-1:0]        source_height;
    logic [DIM_W-1:0]        window_width;
    logic [DIM_W-1:0]        window_height;
    logic [ZOOM_W-1:0]       zoom_factor;
    logic signed [CTR_W-1:0] center_x;
    logic signed [CTR_W-1:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]      xs;
    logic [COORD_W-1:0]      xe;
    logic [COORD_W-1:0]      ys;
    logic [COORD_W-1:0]      ye;
    logic                    fill;
    logic [PIXEL_BITS-1:0]   pix;
    logic signed [CTR_W-1:0] place_x;
    logic signed [CTR_W-1:0] place_y;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [ZOOM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_GINIT, S_GQX, S_GQY, S_GCHK, S_FL, S_FLW, S_FA,
    S_FDIV, S_FDW, S_FE, S_FC, S_GDONE, S_CLS, S_SPAN, S_PUSH
  } front_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
    return r;
  endfunction

  function automatic logic signed [CTR_W-1:0] sat16(input geo_t v);
    logic signed [CTR_W-1:0] r;
    r = v[CTR_W-1:0];
    if (v > geo_t'(SAT_HI)) r = CTR_W'(SAT_HI);
    else if (v < geo_t'(SAT_LO)) r = CTR_W'(SAT_LO);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/czoom_div.sv
`default_nettype none
module czoom_div
  import czoom_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  logic [DIV_W-1:0]     work;
  logic [REM_W-1:0]     rem;
  logic [ZOOM_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [REM_W-1:0]     trial;
  logic                 take;

  assign trial = {rem[REM_W-2:0], work[DIV_W-1]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.dividend;
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      work <= {work[DIV_W-2:0], take};
      rem  <= take ? trial - {1'b0, dvs} : trial;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = work;

endmodule
`default_nettype wire

>>> src/czoom_fifo.sv
`default_nettype none
module czoom_fifo
  import czoom_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      wdata,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rdata,
  output logic      head_valid
);

  cmd_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp;
  logic [FIFO_AW-1:0] rp;
  logic [FIFO_AW:0]   cnt;

  assign full       = cnt == (FIFO_AW+1)'(FIFO_DEPTH);
  assign head_valid = cnt != '0;
  assign rdata      = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= wdata;
  end

endmodule
`default_nettype wire

>>> src/czoom_front.sv
`default_nettype none
module czoom_front
  import czoom_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  cfg_t                       cfg,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIXEL_BITS-1:0] pixel_value,
  input  wire logic                  frame_start,
  output div_req_t                   div_req,
  input  div_rsp_t                   div_rsp,
  output logic                       push,
  output cmd_t                       cmd,
  input  wire logic                  fifo_full
);

  front_state_t state, state_next;

  logic [PIXEL_BITS-1:0]   pix_r;
  logic [COORD_W-1:0]      col;
  logic [COORD_W-1:0]      row;
  logic [ZOOM_W-1:0]       zoom_used;
  logic [COORD_W-1:0]      crop_left;
  logic [COORD_W-1:0]      crop_top;
  logic [DIM_W-1:0]        crop_w;
  logic [DIM_W-1:0]        crop_h;
  logic [DIM_W-1:0]        zw;
  logic [DIM_W-1:0]        zh;
  logic signed [CTR_W-1:0] plx;
  logic signed [CTR_W-1:0] ply;

  geo_t gq [2];
  geo_t gp [2];
  geo_t gd [2];
  geo_t gl [2];
  logic ax;
  geo_t num_r;
  geo_t prod_r;
  logic corr_neg;
  logic corr_on;
  logic [COORD_W-1:0] sp [4];
  logic [1:0]         sidx;

  logic [DIM_W-1:0] sw_c, sh_c, ww_c, wh_c;
  geo_t src_g, win_g, ctr_g, q_min, diff, a_val, b_val, shl_q, b_shl;
  geo_t num_abs, quot_g, d_cur, corr_val, span_v, size_m1, span_c, prod_g;
  logic num_neg, over;
  logic signed [MA_W-1:0]   ma;
  logic signed [PROD_W-1:0] prod;
  logic [COORD_W-1:0] xp, yp;
  logic [DIM_W-1:0]   sp_p;
  logic               in_crop;
  logic [DIM_W-1:0]   col_inc, row_inc;
  logic               advance;
  logic               visible;

  assign sw_c = clamp_dim(cfg.source_width);
  assign sh_c = clamp_dim(cfg.source_height);
  assign ww_c = clamp_dim(cfg.window_width);
  assign wh_c = clamp_dim(cfg.window_height);

  assign src_g  = geo_t'(ax ? sh_c : sw_c);
  assign win_g  = geo_t'(ax ? wh_c : ww_c);
  assign ctr_g  = geo_t'(ax ? cfg.center_y : cfg.center_x);
  assign q_min  = (gq[ax] > win_g) ? win_g : gq[ax];
  assign shl_q  = q_min <<< FRAC_W;
  assign diff   = src_g - gl[ax];
  assign a_val  = (diff + geo_t'(diff[GW-1])) >>> 1;
  assign b_val  = ctr_g - (gq[ax] >>> 1);
  assign b_shl  = b_val <<< FRAC_W;
  assign num_neg = num_r[GW-1];
  assign num_abs = num_neg ? -num_r : num_r;
  assign quot_g  = geo_t'(div_rsp.quotient);
  assign d_cur   = gd[ax];
  assign over    = (d_cur + gl[ax]) > src_g;
  assign corr_val = (d_cur < 0) ? -d_cur : d_cur + gl[ax] - src_g;

  assign prod   = ma * $signed({1'b0, zoom_used});
  assign prod_g = geo_t'(prod);

  assign xp   = col - crop_left;
  assign yp   = row - crop_top;
  assign sp_p = (sidx[1] ? {1'b0, yp} : {1'b0, xp}) + DIM_W'(sidx[0]);
  assign span_v  = (prod_g + geo_t'(2 ** (FRAC_W - 1))) >>> FRAC_W;
  assign size_m1 = geo_t'(sidx[1] ? zh : zw) - geo_t'(1);
  assign span_c  = (span_v > size_m1) ? size_m1 : span_v;

  assign in_crop = (crop_w != '0) && (crop_h != '0) &&
                   (col >= crop_left) &&
                   ({1'b0, col} < DIM_W'(crop_left) + crop_w) &&
                   (row >= crop_top) &&
                   ({1'b0, row} < DIM_W'(crop_top) + crop_h);

  assign visible = (zoom_used != '0) && gq[0] > 0 && gq[1] > 0 && gl[0] > 0 && gl[1] > 0;

  assign col_inc = {1'b0, col} + 1'b1;
  assign row_inc = {1'b0, row} + 1'b1;

  assign cmd.xs      = sp[0];
  assign cmd.xe      = sp[1];
  assign cmd.ys      = sp[2];
  assign cmd.ye      = sp[3];
  assign cmd.fill    = ((sp[1] - sp[0]) > COORD_W'(1)) || ((sp[3] - sp[2]) > COORD_W'(1));
  assign cmd.pix     = pix_r;
  assign cmd.place_x = plx;
  assign cmd.place_y = ply;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next       = state;
    in_stall         = 1'b1;
    push             = 1'b0;
    advance          = 1'b0;
    ma               = '0;
    div_req.start    = 1'b0;
    div_req.dividend = num_abs[DIV_W-1:0];
    div_req.divisor  = zoom_used;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = frame_start ? S_GINIT : S_CLS;
      end
      S_GINIT: state_next = (cfg.zoom_factor == '0) ? S_GDONE : S_GQX;
      S_GQX: begin
        ma = MA_W'(sw_c);
        state_next = S_GQY;
      end
      S_GQY: begin
        ma = MA_W'(sh_c);
        state_next = S_GCHK;
      end
      S_GCHK: begin
        if (gq[0] > geo_t'(ww_c) || gq[1] > geo_t'(wh_c)) state_next = S_FL;
        else state_next = S_GDONE;
      end
      S_FL: begin
        div_req.start    = 1'b1;
        div_req.dividend = shl_q[DIV_W-1:0];
        state_next       = S_FLW;
      end
      S_FLW: if (div_rsp.done) state_next = S_FA;
      S_FA: begin
        ma = a_val[MA_W-1:0];
        state_next = S_FDIV;
      end
      S_FDIV: begin
        div_req.start = 1'b1;
        state_next    = S_FDW;
      end
      S_FDW: if (div_rsp.done) state_next = S_FE;
      S_FE: begin
        ma = corr_val[MA_W-1:0];
        state_next = S_FC;
      end
      S_FC: state_next = ax ? S_GDONE : S_FL;
      S_GDONE: state_next = S_CLS;
      S_CLS: begin
        if (in_crop) state_next = S_SPAN;
        else begin
          advance    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SPAN: begin
        ma = MA_W'(sp_p);
        if (sidx == 2'd3) state_next = S_PUSH;
      end
      S_PUSH: begin
        if (!fifo_full) begin
          push       = 1'b1;
          advance    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      zoom_used <= '0;
      crop_left <= '0;
      crop_top  <= '0;
      crop_w    <= '0;
      crop_h    <= '0;
      zw        <= '0;
      zh        <= '0;
      plx       <= '0;
      ply       <= '0;
    end else begin
      if (advance) begin
        if (col_inc >= sw_c) begin
          col <= '0;
          row <= (row_inc >= sh_c) ? '0 : row_inc[COORD_W-1:0];
        end else begin
          col <= col_inc[COORD_W-1:0];
        end
      end
      case (state)
        S_GINIT: begin
          col <= '0;
          row <= '0;
          zoom_used <= (cfg.zoom_factor > ZOOM_W'(ZOOM_MAX_CODE)) ?
                       ZOOM_W'(ZOOM_MAX_CODE) : cfg.zoom_factor;
        end
        S_GDONE: begin
          plx <= (zoom_used != '0) ? sat16(gp[0]) : '0;
          ply <= (zoom_used != '0) ? sat16(gp[1]) : '0;
          if (visible) begin
            crop_left <= gd[0][COORD_W-1:0];
            crop_top  <= gd[1][COORD_W-1:0];
            crop_w    <= (gl[0] > geo_t'(MAX_DIMENSION)) ?
                         DIM_W'(MAX_DIMENSION) : gl[0][DIM_W-1:0];
            crop_h    <= (gl[1] > geo_t'(MAX_DIMENSION)) ?
                         DIM_W'(MAX_DIMENSION) : gl[1][DIM_W-1:0];
            zw        <= gq[0][DIM_W-1:0];
            zh        <= gq[1][DIM_W-1:0];
          end else begin
            crop_left <= '0;
            crop_top  <= '0;
            crop_w    <= '0;
            crop_h    <= '0;
            zw        <= '0;
            zh        <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: pix_r <= pixel_value;
      S_GINIT: begin
        gp[0] <= geo_t'(ww_c >> 1);
        gp[1] <= geo_t'(wh_c >> 1);
        gd[0] <= '0;
        gd[1] <= '0;
        gl[0] <= geo_t'(sw_c);
        gl[1] <= geo_t'(sh_c);
        gq[0] <= '0;
        gq[1] <= '0;
      end
      S_GQX: gq[0] <= prod_g >>> FRAC_W;
      S_GQY: gq[1] <= prod_g >>> FRAC_W;
      S_GCHK: ax <= 1'b0;
      S_FL: gq[ax] <= q_min;
      S_FLW: if (div_rsp.done) gl[ax] <= quot_g + geo_t'(1);
      S_FA: num_r <= prod_g - b_shl;
      S_FDW: if (div_rsp.done) gd[ax] <= num_neg ? -quot_g : quot_g;
      S_FE: begin
        corr_neg <= d_cur < 0;
        corr_on  <= (d_cur < 0) || over;
        prod_r   <= prod_g;
      end
      S_FC: begin
        if (corr_on) begin
          gq[ax] <= gq[ax] - (prod_r >>> FRAC_W);
          if (corr_neg) begin
            gp[ax] <= gp[ax] + (prod_r >>> (FRAC_W + 1));
            gd[ax] <= '0;
          end else begin
            gp[ax] <= gp[ax] - (prod_r >>> (FRAC_W + 1));
            gl[ax] <= src_g - d_cur;
          end
        end
        ax <= 1'b1;
      end
      S_CLS: sidx <= '0;
      S_SPAN: begin
        sp[sidx] <= span_c[COORD_W-1:0];
        sidx     <= sidx + 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/czoom_back.sv
`default_nettype none
module czoom_back
  import czoom_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  cmd_t                        head,
  input  wire logic                   head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [COORD_W-1:0]          dest_x,
  output logic [COORD_W-1:0]          dest_y,
  output logic [PIXEL_BITS-1:0]       dest_pixel,
  output logic signed [CTR_W-1:0]     place_x,
  output logic signed [CTR_W-1:0]     place_y,
  output logic                        last_write
);

  logic                   started;
  logic [COORD_W-1:0]     x;
  logic [COORD_W-1:0]     y;
  logic [WRITE_CNT_W-1:0] n;
  logic                   empty_cmd;
  logic                   load;
  logic                   x_end;
  logic                   last_now;

  assign empty_cmd = head.fill && (head.xe <= head.xs || head.ye <= head.ys);
  assign load      = started && (!out_valid || !out_stall);
  assign x_end     = ({1'b0, x} + 1'b1) == {1'b0, head.xe};
  assign last_now  = !head.fill || (n == WRITE_CNT_W'(MAX_WRITES - 1)) ||
                     (x_end && (({1'b0, y} + 1'b1) == {1'b0, head.ye}));
  assign pop       = (head_valid && !started && empty_cmd) || (load && last_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!started && head_valid && !empty_cmd) started <= 1'b1;
      else if (load && last_now) started <= 1'b0;
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!started) begin
      x <= head.xs;
      y <= head.ys;
      n <= '0;
    end else if (load && !last_now) begin
      n <= n + 1'b1;
      if (x_end) begin
        x <= head.xs;
        y <= y + 1'b1;
      end else begin
        x <= x + 1'b1;
      end
    end
    if (load) begin
      dest_x     <= x;
      dest_y     <= y;
      dest_pixel <= head.pix;
      place_x    <= head.place_x;
      place_y    <= head.place_y;
      last_write <= last_now;
    end
  end

endmodule
`default_nettype wire

>>> src/cropped_nearest_neighbor_zoom.sv
// Nearest-neighbour zoom with cropping and centring.
// Input: source pixels in raster order on in_valid/in_stall with pixel_value and
// frame_start; frame_start restarts the raster counters and rebuilds the geometry.
// Output: destination writes on out_valid/out_stall (dest_x, dest_y, dest_pixel,
// place_x, place_y, last_write); last_write marks the final write of a pixel.
// Registers sit on the APB port at byte address 4*i; the geometry takes them at the next frame start.
// A pixel outside the crop only advances the raster; one inside has its four span ends
// computed and is queued, and the writer emits one write per cycle while out_stall is
// low (up to 64 per pixel). A frame-start pixel first rebuilds the geometry, which runs
// two divisions per axis on one shared radix-2 divider when the zoomed image is larger
// than the window.
// A four-entry request queue separates classifier and writer, so the classifier
// keeps taking pixels while the receiver stalls until the queue fills.
// Reset returns registers to their defaults and clears geometry, so nothing is drawn
// before the first frame start.
`default_nettype none
`include "assert_macros.svh"
module cropped_nearest_neighbor_zoom
  import czoom_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]           prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIXEL_BITS-1:0] pixel_value,
  input  wire logic                  frame_start,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_W-1:0]         dest_x,
  output logic [COORD_W-1:0]         dest_y,
  output logic [PIXEL_BITS-1:0]      dest_pixel,
  output logic signed [CTR_W-1:0]    place_x,
  output logic signed [CTR_W-1:0]    place_y,
  output logic                       last_write
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     push;
  cmd_t     wcmd;
  logic     fifo_full;
  logic     pop;
  cmd_t     head;
  logic     head_valid;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.source_width  <= DIM_W'(64);
      cfg_r.source_height <= DIM_W'(64);
      cfg_r.window_width  <= DIM_W'(640);
      cfg_r.window_height <= DIM_W'(480);
      cfg_r.zoom_factor   <= ZOOM_W'(256);
      cfg_r.center_x      <= CTR_W'(320);
      cfg_r.center_y      <= CTR_W'(240);
    end else if (wr) begin
      case (idx)
        REG_SOURCE_WIDTH:  cfg_r.source_width  <= pwdata[DIM_W-1:0];
        REG_SOURCE_HEIGHT: cfg_r.source_height <= pwdata[DIM_W-1:0];
        REG_WINDOW_WIDTH:  cfg_r.window_width  <= pwdata[DIM_W-1:0];
        REG_WINDOW_HEIGHT: cfg_r.window_height <= pwdata[DIM_W-1:0];
        REG_ZOOM_FACTOR:   cfg_r.zoom_factor   <= pwdata[ZOOM_W-1:0];
        REG_CENTER_X:      cfg_r.center_x      <= pwdata[CTR_W-1:0];
        REG_CENTER_Y:      cfg_r.center_y      <= pwdata[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SOURCE_WIDTH:  prdata = {{(APB_W-DIM_W){1'b0}}, cfg_r.source_width};
      REG_SOURCE_HEIGHT: prdata = {{(APB_W-DIM_W){1'b0}}, cfg_r.source_height};
      REG_WINDOW_WIDTH:  prdata = {{(APB_W-DIM_W){1'b0}}, cfg_r.window_width};
      REG_WINDOW_HEIGHT: prdata = {{(APB_W-DIM_W){1'b0}}, cfg_r.window_height};
      REG_ZOOM_FACTOR:   prdata = {{(APB_W-ZOOM_W){1'b0}}, cfg_r.zoom_factor};
      REG_CENTER_X:      prdata = {{(APB_W-CTR_W){1'b0}}, cfg_r.center_x};
      REG_CENTER_Y:      prdata = {{(APB_W-CTR_W){1'b0}}, cfg_r.center_y};
      default:           prdata = '0;
    endcase
  end

  czoom_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  czoom_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .frame_start (frame_start),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .push        (push),
    .cmd         (wcmd),
    .fifo_full   (fifo_full)
  );

  czoom_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wdata      (wcmd),
    .full       (fifo_full),
    .pop        (pop),
    .rdata      (head),
    .head_valid (head_valid)
  );

  czoom_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dest_x     (dest_x),
    .dest_y     (dest_y),
    .dest_pixel (dest_pixel),
    .place_x    (place_x),
    .place_y    (place_y),
    .last_write (last_write)
  );

  `ASSERT_ALWAYS(a_queue_no_overflow, !(push && fifo_full), "request queue written while full")
  `ASSERT_ALWAYS(a_queue_no_underflow, !(pop && !head_valid), "request queue read while empty")
  `ASSERT_NEXT(a_div_not_instant, div_req.start, !div_rsp.done, "divider done right after start")

endmodule
`default_nettype wire
